// ===== rtl/wsht_pkg.sv =====
// Shared types and codes for the window stack hit tester.
`timescale 1ns / 1ps
`default_nettype none
package wsht_pkg;

  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_FRONT   = 3'd1;
  localparam logic [2:0] CMD_FOCUS   = 3'd2;
  localparam logic [2:0] CMD_HIT     = 3'd3;
  localparam logic [2:0] CMD_DESTROY = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [15:0]        tag;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [31:0]        color;
  } rec_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic        focus;
    logic [31:0] color;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/wsht_mem.sv =====
// Window record memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module wsht_mem
  import wsht_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire rec_t             wr_rec,
  input  wire logic [IDX_W-1:0] wr_rank,
  input  wire logic [IDX_W-1:0] rd_addr,
  output      rec_t             rd_rec,
  output      logic [IDX_W-1:0] rd_rank
);

  rec_t             rec_mem  [DEPTH];
  logic [IDX_W-1:0] rank_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr]  <= wr_rec;
      rank_mem[wr_addr] <= wr_rank;
    end
    rd_rec  <= rec_mem[rd_addr];
    rd_rank <= rank_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/wsht_seq.sv =====
// Command sequencer: walks the record memory and keeps valid, focus and counters.
`timescale 1ns / 1ps
`default_nettype none
module wsht_seq
  import wsht_pkg::*;
#(
  parameter int MAX_WINDOWS = 16,
  parameter int IDX_W = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [2:0]         command,
  input  wire logic [3:0]         slot,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic [14:0]        span_w,
  input  wire logic [14:0]        span_h,
  input  wire logic [31:0]        fill_color,
  output      logic               mem_wr_en,
  output      logic [IDX_W-1:0]   mem_wr_addr,
  output      rec_t               mem_wr_rec,
  output      logic [IDX_W-1:0]   mem_wr_rank,
  output      logic [IDX_W-1:0]   mem_rd_addr,
  input  wire rec_t               mem_rd_rec,
  input  wire logic [IDX_W-1:0]   mem_rd_rank,
  output      logic               res_valid,
  input  wire logic               res_take,
  output      res_t               res,
  output      logic [IDX_W-1:0]   res_slot,
  output      logic [IDX_W-1:0]   res_rank
);

  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOWS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_CAP  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]             state;
  logic [MAX_WINDOWS-1:0] valid;
  logic                   focus_valid;
  logic [IDX_W-1:0]       focus_slot;
  logic [CNT_W-1:0]       live_count;
  logic [15:0]            next_tag;

  logic [2:0]             op;
  logic                   plain;
  logic [1:0]             plain_status;
  logic [IDX_W-1:0]       s_idx;
  logic signed [15:0]     c_left;
  logic signed [15:0]     c_top;
  logic [14:0]            c_w;
  logic [14:0]            c_h;
  logic [31:0]            c_color;
  logic [CNT_W-1:0]       rd_ptr;
  logic                   p_valid;
  logic [IDX_W-1:0]       p_idx;
  rec_t                   r_rec;
  logic [IDX_W-1:0]       r_rank;
  logic                   free_found;
  logic [IDX_W-1:0]       free_slot;
  logic                   found;
  logic [IDX_W-1:0]       best_slot;
  rec_t                   best_rec;
  logic [IDX_W-1:0]       best_rank;

  logic [8:0]             s_wide;
  logic                   s_ok;
  logic                   accept;
  logic                   commit;
  logic                   p_live;
  logic signed [17:0]     px_w, py_w, left_w, top_w, right_w, bottom_w;
  logic                   pt_hit;
  logic                   walk_wr;
  logic [IDX_W-1:0]       walk_rank;

  assign s_wide   = 9'(slot);
  assign s_ok     = (s_wide < 9'(MAX_WINDOWS)) && valid[s_wide[IDX_W-1:0]];
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign res_valid = (state == S_FIN);
  assign commit   = res_valid && res_take;
  assign p_live   = valid[p_idx];

  assign mem_rd_addr = (state == S_LOOK) ? s_idx : rd_ptr[IDX_W-1:0];

  // half-open containment test against the record coming out of memory
  assign px_w     = 18'(c_left);
  assign py_w     = 18'(c_top);
  assign left_w   = 18'(mem_rd_rec.left);
  assign top_w    = 18'(mem_rd_rec.top);
  assign right_w  = left_w + $signed({3'b000, mem_rd_rec.width});
  assign bottom_w = top_w + $signed({3'b000, mem_rd_rec.height});
  assign pt_hit   = (px_w >= left_w) && (px_w < right_w) &&
                    (py_w >= top_w) && (py_w < bottom_w);

  always_comb begin
    walk_wr   = 1'b0;
    walk_rank = mem_rd_rank;
    if (p_valid && p_live) begin
      unique case (op)
        CMD_CREATE: begin
          walk_wr   = 1'b1;
          walk_rank = mem_rd_rank + 1'b1;
        end
        CMD_FRONT: begin
          if (p_idx == s_idx) begin
            walk_wr   = 1'b1;
            walk_rank = '0;
          end else if (mem_rd_rank < r_rank) begin
            walk_wr   = 1'b1;
            walk_rank = mem_rd_rank + 1'b1;
          end
        end
        CMD_DESTROY: begin
          if (mem_rd_rank > r_rank) begin
            walk_wr   = 1'b1;
            walk_rank = mem_rd_rank - 1'b1;
          end
        end
        default: begin
          walk_wr = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    mem_wr_en   = walk_wr;
    mem_wr_addr = p_idx;
    mem_wr_rec  = mem_rd_rec;
    mem_wr_rank = walk_rank;
    if (commit && !plain && op == CMD_CREATE) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = free_slot;
      mem_wr_rec  = '{tag: next_tag, left: c_left, top: c_top,
                      width: c_w, height: c_h, color: c_color};
      mem_wr_rank = '0;
    end
  end

  always_comb begin
    res      = '0;
    res_slot = '0;
    res_rank = '0;
    if (plain) begin
      res.status = plain_status;
    end else begin
      unique case (op)
        CMD_CREATE: begin
          res.tag   = next_tag;
          res.focus = focus_valid && (focus_slot == free_slot);
          res.color = c_color;
          res_slot  = free_slot;
        end
        CMD_HIT: begin
          if (found) begin
            res.tag   = best_rec.tag;
            res.focus = focus_valid && (focus_slot == best_slot);
            res.color = best_rec.color;
            res_slot  = best_slot;
            res_rank  = best_rank;
          end else begin
            res.status = ST_MISS;
          end
        end
        CMD_FRONT: begin
          res.tag   = r_rec.tag;
          res.focus = focus_valid && (focus_slot == s_idx);
          res.color = r_rec.color;
          res_slot  = s_idx;
        end
        CMD_FOCUS: begin
          res.tag   = r_rec.tag;
          res.focus = 1'b1;
          res.color = r_rec.color;
          res_slot  = s_idx;
          res_rank  = r_rank;
        end
        CMD_DESTROY: begin
          res.tag   = r_rec.tag;
          res.color = r_rec.color;
          res_slot  = s_idx;
          res_rank  = r_rank;
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      focus_valid <= 1'b0;
      focus_slot  <= '0;
      live_count  <= '0;
      next_tag    <= 16'd1;
      p_valid     <= 1'b0;
      rd_ptr      <= '0;
      plain       <= 1'b0;
      free_found  <= 1'b0;
      found       <= 1'b0;
    end else begin
      p_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= command;
            s_idx      <= s_wide[IDX_W-1:0];
            c_left     <= pos_x;
            c_top      <= pos_y;
            c_w        <= span_w;
            c_h        <= span_h;
            c_color    <= fill_color;
            rd_ptr     <= '0;
            free_found <= 1'b0;
            found      <= 1'b0;
            plain      <= 1'b0;
            priority case (command)
              CMD_CREATE: begin
                if (live_count >= CNT_W'(MAX_WINDOWS)) begin
                  plain        <= 1'b1;
                  plain_status <= ST_FULL;
                  state        <= S_FIN;
                end else begin
                  state <= S_WALK;
                end
              end
              CMD_HIT: state <= S_WALK;
              CMD_FRONT, CMD_FOCUS, CMD_DESTROY: begin
                if (s_ok) begin
                  state <= S_LOOK;
                end else begin
                  plain        <= 1'b1;
                  plain_status <= ST_EMPTY;
                  state        <= S_FIN;
                end
              end
              default: begin
                plain        <= 1'b1;
                plain_status <= ST_OK;
                state        <= S_FIN;
              end
            endcase
          end
        end
        S_LOOK: state <= S_CAP;
        S_CAP: begin
          r_rec  <= mem_rd_rec;
          r_rank <= mem_rd_rank;
          state  <= (op == CMD_FOCUS) ? S_FIN : S_WALK;
        end
        S_WALK: begin
          if (rd_ptr < CNT_W'(MAX_WINDOWS)) begin
            p_valid <= 1'b1;
            p_idx   <= rd_ptr[IDX_W-1:0];
            rd_ptr  <= rd_ptr + 1'b1;
          end
          if (p_valid) begin
            if (op == CMD_CREATE && !p_live && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= p_idx;
            end
            if (op == CMD_HIT && p_live && pt_hit && (!found || mem_rd_rank < best_rank)) begin
              found     <= 1'b1;
              best_slot <= p_idx;
              best_rec  <= mem_rd_rec;
              best_rank <= mem_rd_rank;
            end
            if (p_idx == LAST_IDX) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
            if (!plain) begin
              unique case (op)
                CMD_CREATE: begin
                  valid[free_slot] <= 1'b1;
                  live_count       <= live_count + 1'b1;
                  next_tag         <= next_tag + 16'd1;
                end
                CMD_FOCUS: begin
                  focus_valid <= 1'b1;
                  focus_slot  <= s_idx;
                end
                CMD_DESTROY: begin
                  valid[s_idx] <= 1'b0;
                  if (live_count != '0) begin
                    live_count <= live_count - 1'b1;
                  end
                  if (focus_valid && focus_slot == s_idx) begin
                    focus_valid <= 1'b0;
                    focus_slot  <= '0;
                  end
                end
                default: begin
                  focus_valid <= focus_valid;
                end
              endcase
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(live_count))
    else $error("live count differs from number of valid entries");

  a_focus_live: assert property (@(posedge clk) disable iff (rst)
    focus_valid |-> valid[focus_slot])
    else $error("focus held by an empty slot");

  a_walk_only: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == S_WALK))
    else $error("walk data outside walk");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CNT_W'(MAX_WINDOWS))
    else $error("live count above table size");

endmodule
`default_nettype wire

// ===== rtl/window_stack_hit_tester.sv =====
// Top level: z-ordered window table with hit test, record memory and output register.
// Create and hit test walk all memory entries; front and destroy read the addressed
// record, then walk; focus only reads it; error and unused commands report without a memory access.
// New items wait until the result is taken; the memory walk reads one entry per cycle.
// Reset (rst, synchronous): clears valid bits, focus, live count, tag counter to one.
// Record memory contents are not cleared; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module window_stack_hit_tester
  import wsht_pkg::*;
#(
  parameter int MAX_WINDOWS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [2:0]         command,
  input  wire logic [3:0]         slot,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic [14:0]        span_w,
  input  wire logic [14:0]        span_h,
  input  wire logic [31:0]        fill_color,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         status,
  output      logic [3:0]         hit_slot,
  output      logic [15:0]        window_tag,
  output      logic [3:0]         z_rank,
  output      logic               has_focus,
  output      logic [31:0]        color_out
);

  localparam int IDX_W = $clog2(MAX_WINDOWS);

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  rec_t             mem_wr_rec;
  logic [IDX_W-1:0] mem_wr_rank;
  logic [IDX_W-1:0] mem_rd_addr;
  rec_t             mem_rd_rec;
  logic [IDX_W-1:0] mem_rd_rank;
  logic             res_valid;
  logic             res_take;
  res_t             res;
  logic [IDX_W-1:0] res_slot;
  logic [IDX_W-1:0] res_rank;
  logic [7:0]       slot_wide;
  logic [7:0]       rank_wide;

  wsht_mem #(
    .DEPTH(MAX_WINDOWS),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_rec (mem_wr_rec),
    .wr_rank(mem_wr_rank),
    .rd_addr(mem_rd_addr),
    .rd_rec (mem_rd_rec),
    .rd_rank(mem_rd_rank)
  );

  wsht_seq #(
    .MAX_WINDOWS(MAX_WINDOWS),
    .IDX_W(IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .slot       (slot),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .span_w     (span_w),
    .span_h     (span_h),
    .fill_color (fill_color),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_rec (mem_wr_rec),
    .mem_wr_rank(mem_wr_rank),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_rec (mem_rd_rec),
    .mem_rd_rank(mem_rd_rank),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .res_slot   (res_slot),
    .res_rank   (res_rank)
  );

  assign res_take  = !out_valid || out_ready;
  assign slot_wide = 8'(res_slot);
  assign rank_wide = 8'(res_rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status     <= res.status;
      hit_slot   <= slot_wide[3:0];
      window_tag <= res.tag;
      z_rank     <= rank_wide[3:0];
      has_focus  <= res.focus;
      color_out  <= res.color;
    end
  end

endmodule
`default_nettype wire

// ===== tb/window_stack_hit_tester_tb.sv =====
// Testbench for window_stack_hit_tester: a stack tracker predicts every report; random traffic.
`timescale 1ns / 1ps
module window_stack_hit_tester_tb;
  import wsht_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int RANDOM_ITEMS   = 1630;
  localparam int QUIET_TAIL     = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * NUM_SLOTS + 8;
  localparam int MAX_SHOWN      = 10;

  // commands that the block decodes as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] tag;
    logic [3:0]  rank;
    logic        focus;
    logic [31:0] color;
  } window_report_t;

  function automatic string show(window_report_t r);
    return $sformatf("status=%0d slot=%0d tag=%h rank=%0d focus=%0b color=%h",
                     r.status, r.slot, r.tag, r.rank, r.focus, r.color);
  endfunction

  class window_stack_tracker;
    bit             live [NUM_SLOTS];
    logic [15:0]    win_tag [NUM_SLOTS];
    int             win_left [NUM_SLOTS];
    int             win_top [NUM_SLOTS];
    int             win_w [NUM_SLOTS];
    int             win_h [NUM_SLOTS];
    logic [31:0]    win_color [NUM_SLOTS];
    int             win_rank [NUM_SLOTS];
    bit             focus_on;
    int             focus_idx;
    int             live_count;
    logic [15:0]    next_tag;
    window_report_t due_reports[$];
    int             mismatches;
    int             cmd_seen [8];
    int             status_seen [4];

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        live[i] = 1'b0;
        win_rank[i] = 0;
      end
      for (int i = 0; i < 8; i++) cmd_seen[i] = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      focus_on = 1'b0;
      focus_idx = 0;
      live_count = 0;
      next_tag = 16'd1;
      mismatches = 0;
    endfunction

    function window_report_t slot_report(int s, bit show_focus);
      window_report_t r;
      r.status = ST_OK;
      r.slot   = s[3:0];
      r.tag    = win_tag[s];
      r.rank   = win_rank[s][3:0];
      r.focus  = show_focus && focus_on && (focus_idx == s);
      r.color  = win_color[s];
      return r;
    endfunction

    function window_report_t error_report(logic [1:0] st);
      window_report_t r;
      r = '0;
      r.status = st;
      return r;
    endfunction

    function int pick_live();
      int k;
      if (live_count == 0) return -1;
      k = $urandom_range(0, live_count - 1);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (live[i]) begin
          if (k == 0) return i;
          k--;
        end
      end
      return -1;
    endfunction

    function void note_command(logic [2:0] cmd, logic [3:0] sl, logic signed [15:0] x,
                               logic signed [15:0] y, logic [14:0] w, logic [14:0] h,
                               logic [31:0] c);
      int s, free_idx, best, r, px, py;
      window_report_t rep;
      s = int'(sl);
      px = int'(x);
      py = int'(y);
      cmd_seen[cmd]++;
      rep = error_report(ST_OK);
      case (cmd)
        CMD_CREATE: begin
          free_idx = -1;
          for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!live[i]) free_idx = i;
          if (free_idx < 0 || live_count >= NUM_SLOTS) begin
            rep = error_report(ST_FULL);
          end else begin
            for (int i = 0; i < NUM_SLOTS; i++) if (live[i]) win_rank[i]++;
            live[free_idx]      = 1'b1;
            win_tag[free_idx]   = next_tag;
            next_tag            = next_tag + 16'd1;
            win_left[free_idx]  = px;
            win_top[free_idx]   = py;
            win_w[free_idx]     = int'(w);
            win_h[free_idx]     = int'(h);
            win_color[free_idx] = c;
            win_rank[free_idx]  = 0;
            live_count++;
            rep = slot_report(free_idx, 1'b1);
          end
        end
        CMD_HIT: begin
          best = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (live[i] && px >= win_left[i] && px < win_left[i] + win_w[i] &&
                py >= win_top[i] && py < win_top[i] + win_h[i]) begin
              if (best < 0 || win_rank[i] < win_rank[best]) best = i;
            end
          end
          rep = (best < 0) ? error_report(ST_MISS) : slot_report(best, 1'b1);
        end
        CMD_FRONT, CMD_FOCUS, CMD_DESTROY: begin
          if (!live[s]) begin
            rep = error_report(ST_EMPTY);
          end else begin
            r = win_rank[s];
            if (cmd == CMD_FRONT) begin
              for (int i = 0; i < NUM_SLOTS; i++)
                if (live[i] && win_rank[i] < r) win_rank[i]++;
              win_rank[s] = 0;
              rep = slot_report(s, 1'b1);
            end else if (cmd == CMD_FOCUS) begin
              focus_on = 1'b1;
              focus_idx = s;
              rep = slot_report(s, 1'b1);
            end else begin
              rep = slot_report(s, 1'b0);
              for (int i = 0; i < NUM_SLOTS; i++)
                if (live[i] && win_rank[i] > r) win_rank[i]--;
              if (focus_on && focus_idx == s) begin
                focus_on = 1'b0;
                focus_idx = 0;
              end
              live[s] = 1'b0;
              if (live_count > 0) live_count--;
            end
          end
        end
        default: rep = error_report(ST_OK);
      endcase
      status_seen[rep.status]++;
      due_reports.push_back(rep);
    endfunction

    function void check_result(window_report_t got);
      window_report_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected report, none pending: %s", show(got));
        return;
      end
      want = due_reports.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("report mismatch at %0t\n  expected %s\n  actual   %s",
                   $realtime, show(want), show(got));
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         command;
  logic [3:0]         slot;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        span_w;
  logic [14:0]        span_h;
  logic [31:0]        fill_color;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [3:0]         hit_slot;
  logic [15:0]        window_tag;
  logic [3:0]         z_rank;
  logic               has_focus;
  logic [31:0]        color_out;

  window_stack_tracker tracker;
  int                  gap_pct;
  int                  stall_pct;
  int                  idle_cycles;
  bit                  timed_out;

  window_stack_hit_tester #(
    .MAX_WINDOWS(NUM_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .slot      (slot),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .span_w    (span_w),
    .span_h    (span_h),
    .fill_color(fill_color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .hit_slot  (hit_slot),
    .window_tag(window_tag),
    .z_rank    (z_rank),
    .has_focus (has_focus),
    .color_out (color_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts, with ready raised again between bursts
  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 1) begin
        hold--;
        out_ready <= 1'b0;
      end else if (hold == 1) begin
        hold = 0;
        out_ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1)
      tracker.check_result({status, hit_slot, window_tag, z_rank, has_focus, color_out});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_item(input logic [2:0] cmd, input logic [3:0] sl,
                           input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic [14:0] w, input logic [14:0] h, input logic [31:0] c);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    slot       <= sl;
    pos_x      <= x;
    pos_y      <= y;
    span_w     <= w;
    span_h     <= h;
    fill_color <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_command(cmd, sl, x, y, w, h, c);
  endtask

  function automatic logic signed [15:0] extreme_pos();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic logic [14:0] extreme_span();
    case ($urandom_range(0, 3))
      0:       return 15'd0;
      1:       return 15'd1;
      2:       return 15'h7ffe;
      default: return 15'h7fff;
    endcase
  endfunction

  // point on or next to one edge of a window, or anywhere from its low edge up to one past its high edge
  function automatic logic signed [15:0] near_edge(int lo, int span);
    int v;
    case ($urandom_range(0, 5))
      0:       v = lo - 1;
      1:       v = lo;
      2:       v = lo + span - 1;
      3:       v = lo + span;
      default: v = lo + int'($urandom_range(0, span));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send_random_item(int create_pct);
    logic [2:0]         cmd;
    logic [3:0]         sl;
    logic signed [15:0] x, y;
    logic [14:0]        w, h;
    int                 pick, mode, s;
    sl = 4'($urandom);
    x = 16'($urandom);
    y = 16'($urandom);
    w = 15'($urandom);
    h = 15'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < create_pct) begin
      cmd = CMD_CREATE;
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        // crowded region so windows overlap
        x = 16'(int'($urandom_range(0, 200)) - 100);
        y = 16'(int'($urandom_range(0, 200)) - 100);
        w = 15'($urandom_range(0, 120));
        h = 15'($urandom_range(0, 120));
      end else if (mode < 85) begin
        x = extreme_pos();
        y = extreme_pos();
        w = extreme_span();
        h = extreme_span();
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cmd = CMD_HIT;
        s = tracker.pick_live();
        if (s >= 0 && $urandom_range(0, 99) < 80) begin
          x = near_edge(tracker.win_left[s], tracker.win_w[s]);
          y = near_edge(tracker.win_top[s], tracker.win_h[s]);
        end
      end else if (pick < 95) begin
        cmd = (pick < 62) ? CMD_DESTROY : (pick < 80) ? CMD_FRONT : CMD_FOCUS;
        s = tracker.pick_live();
        if (s >= 0 && $urandom_range(0, 99) < 85) sl = s[3:0];
      end else begin
        cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
    end
    send_item(cmd, sl, x, y, w, h, $urandom);
  endtask

  task automatic run_directed();
    send_item(CMD_HIT,     0,  0,      0,      0,     0,     $urandom);
    send_item(CMD_FRONT,   0,  0,      0,      0,     0,     $urandom);
    send_item(CMD_FOCUS,   5,  0,      0,      0,     0,     $urandom);
    send_item(CMD_DESTROY, 15, 0,      0,      0,     0,     $urandom);
    send_item(CMD_CREATE,  4'($urandom), -32768, -32768, 32767, 32767, 32'hffffffff);
    send_item(CMD_CREATE,  4'($urandom), 32767,  32767,  32767, 32767, 32'h00000000);
    send_item(CMD_CREATE,  4'($urandom), 0,      0,      0,     100,   32'h12345678);
    send_item(CMD_CREATE,  4'($urandom), -10,    -10,    20,    20,    32'ha5a5a5a5);
    send_item(CMD_CREATE,  4'($urandom), 20,     20,     50,    0,     32'h5a5a5a5a);
    send_item(CMD_HIT,     4'($urandom), -1,     -1,     0,     0,     $urandom);
    send_item(CMD_HIT,     4'($urandom), 9,      9,      0,     0,     $urandom);
    send_item(CMD_HIT,     4'($urandom), 10,     10,     0,     0,     $urandom);
    send_item(CMD_HIT,     4'($urandom), -32768, -32768, 0,     0,     $urandom);
    send_item(CMD_HIT,     4'($urandom), 32767,  32767,  0,     0,     $urandom);
    send_item(CMD_HIT,     4'($urandom), 0,      50,     0,     0,     $urandom);
    send_item(CMD_HIT,     4'($urandom), 30,     20,     0,     0,     $urandom);
    send_item(CMD_FRONT,   0,  16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
              $urandom);
    send_item(CMD_HIT,     4'($urandom), -5,     -5,     0,     0,     $urandom);
    send_item(CMD_FOCUS,   3,  16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
              $urandom);
    send_item(CMD_HIT,     4'($urandom), 0,      0,      0,     0,     $urandom);
    send_item(CMD_FOCUS,   1,  16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
              $urandom);
    send_item(CMD_DESTROY, 1,  16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
              $urandom);
    send_item(CMD_DESTROY, 3,  16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
              $urandom);
    send_item(CMD_SPARE_LO, 4'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
              15'($urandom), $urandom);
    send_item(3'(CMD_SPARE_LO + 1), 4'($urandom), 16'($urandom), 16'($urandom),
              15'($urandom), 15'($urandom), $urandom);
    send_item(CMD_SPARE_HI, 4'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
              15'($urandom), $urandom);
    send_item(CMD_CREATE,  4'($urandom), 100,    100,    1,     1,     $urandom);
  endtask

  task automatic run_random();
    int sent, phase_end, create_pct, busy_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_end = sent + $urandom_range(60, 140);
      create_pct = $urandom_range(15, 65);
      case ($urandom_range(0, 3))
        0:       busy_pct = 0;
        1:       busy_pct = 8;
        2:       busy_pct = 20;
        default: busy_pct = 40;
      endcase
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
          gap_pct = 0;
          stall_pct = 0;
        end else begin
          gap_pct = busy_pct;
          stall_pct = busy_pct / 2;
        end
        send_random_item(create_pct);
        sent++;
      end
    end
  endtask

  task automatic run_all();
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    tracker = new();
    gap_pct = 20;
    stall_pct = 10;
    timed_out = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= CMD_CREATE;
    slot       <= '0;
    pos_x      <= '0;
    pos_y      <= '0;
    span_w     <= '0;
    span_h     <= '0;
    fill_color <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      run_all();
      begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    if (timed_out) begin
      $display("watchdog: no transfer for %0d cycles, %0d reports pending",
               WATCHDOG_LIMIT, tracker.due_reports.size());
      $display("*** FAILED ***");
    end else begin
      $display("covered: create %0d, front %0d, focus %0d, hit test %0d, destroy %0d, spare %0d",
               tracker.cmd_seen[CMD_CREATE], tracker.cmd_seen[CMD_FRONT],
               tracker.cmd_seen[CMD_FOCUS], tracker.cmd_seen[CMD_HIT],
               tracker.cmd_seen[CMD_DESTROY],
               tracker.cmd_seen[CMD_SPARE_LO] + tracker.cmd_seen[CMD_SPARE_LO + 1] +
               tracker.cmd_seen[CMD_SPARE_HI]);
      $display("reports: ok %0d, table full %0d, empty slot %0d, miss %0d; mismatches %0d",
               tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
               tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_MISS],
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.due_reports.size() == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule
